@@ design/pfkd_pkg.sv @@
// ----------------------------------------------------------------------------
// pfkd_pkg
// Shared types and constants of the process FIFO with delete by key.
// ----------------------------------------------------------------------------
package pfkd_pkg;

  // default number of queue slots
  localparam int unsigned QueueDepthDef = 16;

  // field widths of the words
  localparam int unsigned ActW  = 2;
  localparam int unsigned PrioW = 8;
  localparam int unsigned PidW  = 16;
  localparam int unsigned RunW  = 16;
  localparam int unsigned StatW = 2;
  localparam int unsigned OccW  = 5;

  // request codes
  typedef enum logic [ActW-1:0] {
    ACT_PUSH   = 2'd0,
    ACT_POP    = 2'd1,
    ACT_DELETE = 2'd2,
    ACT_NONE   = 2'd3
  } action_e;

  // response codes
  typedef enum logic [StatW-1:0] {
    STAT_OK   = 2'd0,
    STAT_NONE = 2'd1,
    STAT_FULL = 2'd2
  } status_e;

  // one stored descriptor
  typedef struct packed {
    logic [PrioW-1:0] prio;
    logic [PidW-1:0]  pid;
    logic [RunW-1:0]  runtime;
  } entry_t;

  // controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_POP_WAIT,
    S_SCAN_CMP,
    S_SHIFT_WR,
    S_SHIFT_CHK,
    S_RESP
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic    load_item;
    logic    push_wr;
    logic    rd_en;
    logic    rd_next;
    logic    walk_init;
    logic    step;
    logic    shift_wr;
    logic    got_latch;
    logic    pop_commit;
    logic    del_commit;
    logic    set_status;
    status_e status;
    logic    out_load;
  } pfkd_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [ActW-1:0] action;
    logic            full;
    logic            empty;
    logic            pid_match;
    logic            last;
    logic            out_free;
  } pfkd_stat_t;

endpackage

@@ design/pfkd_if.sv @@
// ----------------------------------------------------------------------------
// pfkd_if
// Valid/ready channels for request words and response words.
// ----------------------------------------------------------------------------

// request channel
interface pfkd_in_if;
  logic                      valid;
  logic                      ready;
  logic [pfkd_pkg::ActW-1:0]  action;
  logic [pfkd_pkg::PrioW-1:0] in_priority;
  logic [pfkd_pkg::PidW-1:0]  in_pid;
  logic [pfkd_pkg::RunW-1:0]  in_runtime;

  modport source (output valid, action, in_priority, in_pid, in_runtime, input ready);
  modport sink   (input valid, action, in_priority, in_pid, in_runtime, output ready);
endinterface

// response channel
interface pfkd_out_if;
  logic                      valid;
  logic                      ready;
  logic [pfkd_pkg::StatW-1:0] status;
  logic [pfkd_pkg::PrioW-1:0] out_priority;
  logic [pfkd_pkg::PidW-1:0]  out_pid;
  logic [pfkd_pkg::RunW-1:0]  out_runtime;
  logic [pfkd_pkg::OccW-1:0]  occupancy;

  modport source (output valid, status, out_priority, out_pid, out_runtime, occupancy,
                  input ready);
  modport sink   (input valid, status, out_priority, out_pid, out_runtime, occupancy,
                  output ready);
endinterface

@@ design/pfkd_ctrl.sv @@
// ----------------------------------------------------------------------------
// pfkd_ctrl
// Controller: decodes a request and sequences reads, scans and shifts.
// ----------------------------------------------------------------------------
module pfkd_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  pfkd_pkg::pfkd_stat_t stat_i,
  output pfkd_pkg::pfkd_cmd_t  cmd_o
);
  import pfkd_pkg::*;

  state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_DECODE;
      end
      S_DECODE: begin
        case (stat_i.action)
          ACT_POP:    state_d = stat_i.empty ? S_RESP : S_POP_WAIT;
          ACT_DELETE: state_d = stat_i.empty ? S_RESP : S_SCAN_CMP;
          default:    state_d = S_RESP;
        endcase
      end
      S_POP_WAIT: state_d = S_RESP;
      S_SCAN_CMP: begin
        if (stat_i.last) state_d = S_RESP;
        else if (stat_i.pid_match) state_d = S_SHIFT_WR;
        else state_d = S_SCAN_CMP;
      end
      S_SHIFT_WR: state_d = S_SHIFT_CHK;
      S_SHIFT_CHK: begin
        state_d = stat_i.last ? S_RESP : S_SHIFT_WR;
      end
      S_RESP: begin
        if (stat_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.load_item = in_valid_i;
      end
      S_DECODE: begin
        cmd_o.set_status = 1'b1;
        case (stat_i.action)
          ACT_PUSH: begin
            cmd_o.status  = stat_i.full ? STAT_FULL : STAT_OK;
            cmd_o.push_wr = !stat_i.full;
          end
          ACT_POP: begin
            cmd_o.status = STAT_NONE;
            cmd_o.rd_en  = !stat_i.empty;
          end
          ACT_DELETE: begin
            cmd_o.status    = STAT_NONE;
            cmd_o.rd_en     = !stat_i.empty;
            cmd_o.walk_init = 1'b1;
          end
          default: cmd_o.status = STAT_NONE;
        endcase
      end
      S_POP_WAIT: begin
        cmd_o.got_latch  = 1'b1;
        cmd_o.pop_commit = 1'b1;
        cmd_o.set_status = 1'b1;
        cmd_o.status     = STAT_OK;
      end
      S_SCAN_CMP: begin
        if (stat_i.pid_match) begin
          cmd_o.got_latch  = 1'b1;
          cmd_o.set_status = 1'b1;
          cmd_o.status     = STAT_OK;
          cmd_o.del_commit = stat_i.last;
          cmd_o.rd_en      = !stat_i.last;
          cmd_o.rd_next    = !stat_i.last;
        end else if (!stat_i.last) begin
          cmd_o.step    = 1'b1;
          cmd_o.rd_en   = 1'b1;
          cmd_o.rd_next = 1'b1;
        end
      end
      S_SHIFT_WR: begin
        cmd_o.shift_wr = 1'b1;
        cmd_o.step     = 1'b1;
      end
      S_SHIFT_CHK: begin
        cmd_o.del_commit = stat_i.last;
        cmd_o.rd_en      = !stat_i.last;
        cmd_o.rd_next    = !stat_i.last;
      end
      S_RESP: begin
        cmd_o.out_load = stat_i.out_free;
      end
      default: ;
    endcase
  end

endmodule

@@ design/pfkd_dp.sv @@
// ----------------------------------------------------------------------------
// pfkd_dp
// Datapath: circular entry memory, pointers, scan position, response register.
// ----------------------------------------------------------------------------
module pfkd_dp #(
  parameter int unsigned QueueDepth = pfkd_pkg::QueueDepthDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  pfkd_pkg::pfkd_cmd_t        cmd_i,
  output pfkd_pkg::pfkd_stat_t       stat_o,
  input  logic [pfkd_pkg::ActW-1:0]  action_i,
  input  pfkd_pkg::entry_t           entry_i,
  input  logic                       out_ready_i,
  output logic                       out_valid_o,
  output logic [pfkd_pkg::StatW-1:0] out_status_o,
  output pfkd_pkg::entry_t           out_entry_o,
  output logic [pfkd_pkg::OccW-1:0]  out_occ_o
);
  import pfkd_pkg::*;

  localparam int unsigned AddrW = $clog2(QueueDepth);
  localparam int unsigned CntW  = $clog2(QueueDepth + 1);
  localparam logic [AddrW-1:0] LastAddr = AddrW'(QueueDepth - 1);
  localparam logic [CntW-1:0]  FullCnt  = CntW'(QueueDepth);

  function automatic logic [AddrW-1:0] wrap_inc(input logic [AddrW-1:0] p);
    return (p == LastAddr) ? '0 : p + 1'b1;
  endfunction

  logic [ActW-1:0]  action_q;
  entry_t           item_q;
  entry_t           mem_q [QueueDepth];
  entry_t           rd_data_q;
  entry_t           got_q;
  status_e          res_status_q;
  logic [AddrW-1:0] head_q, tail_q, walk_q;
  logic [CntW-1:0]  count_q, pos_q;
  logic             out_valid_q;
  logic [StatW-1:0] out_status_q;
  entry_t           out_entry_q;
  logic [OccW-1:0]  out_occ_q;

  logic [AddrW-1:0]     walk_nxt, rd_addr, wr_addr;
  logic                 wr_en;
  entry_t               wr_data;
  logic [CntW:0]        pos_inc;
  logic [OccW+CntW-1:0] occ_ext;

  assign walk_nxt = wrap_inc(walk_q);
  assign rd_addr  = cmd_i.rd_next ? walk_nxt : head_q;
  assign pos_inc  = {1'b0, pos_q} + 1'b1;
  assign occ_ext  = {OccW'(0), count_q};

  // write port: push at tail, or shift an entry one slot toward the front
  always_comb begin
    wr_en   = cmd_i.push_wr | cmd_i.shift_wr;
    wr_addr = cmd_i.push_wr ? tail_q : walk_q;
    wr_data = cmd_i.push_wr ? item_q : rd_data_q;
  end

  // entry memory
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (cmd_i.rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  // request word and removed entry
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      action_q <= action_i;
      item_q   <= entry_i;
    end
    if (cmd_i.load_item) begin
      got_q <= '0;
    end else if (cmd_i.got_latch) begin
      got_q <= rd_data_q;
    end
    if (cmd_i.set_status) begin
      res_status_q <= cmd_i.status;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      walk_q  <= '0;
      count_q <= '0;
      pos_q   <= '0;
    end else begin
      if (cmd_i.push_wr) begin
        tail_q  <= wrap_inc(tail_q);
        count_q <= count_q + 1'b1;
      end else if (cmd_i.pop_commit) begin
        head_q  <= wrap_inc(head_q);
        count_q <= count_q - 1'b1;
      end else if (cmd_i.del_commit) begin
        tail_q  <= walk_q;
        count_q <= count_q - 1'b1;
      end
      if (cmd_i.walk_init) begin
        walk_q <= head_q;
        pos_q  <= '0;
      end else if (cmd_i.step) begin
        walk_q <= walk_nxt;
        pos_q  <= pos_inc[CntW-1:0];
      end
    end
  end

  // response output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_status_q <= res_status_q;
      out_entry_q  <= got_q;
      out_occ_q    <= occ_ext[OccW-1:0];
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_entry_o  = out_entry_q;
  assign out_occ_o    = out_occ_q;

  // status toward the controller
  always_comb begin
    stat_o.action    = action_q;
    stat_o.full      = (count_q == FullCnt);
    stat_o.empty     = (count_q == '0);
    stat_o.pid_match = (rd_data_q.pid == item_q.pid);
    stat_o.last      = (pos_inc >= {1'b0, count_q});
    stat_o.out_free  = !out_valid_q || out_ready_i;
  end

endmodule

@@ design/process_fifo_with_key_delete_top.sv @@
// ----------------------------------------------------------------------------
// process_fifo_with_key_delete_top
// Bounded FIFO of process descriptors with push, pop and delete by pid.
// ----------------------------------------------------------------------------
//  channel | dir | handshake   | word
//  in_i    | in  | valid/ready | action, in_priority, in_pid, in_runtime
//  out_o   | out | valid/ready | status, out_priority, out_pid, out_runtime, occupancy
//
//  One request at a time; in_i.ready is high only while no request is open.
//  Push runs through decode and response; pop adds a read wait state; delete
//  compares one scanned entry per compare state, then moves each entry behind
//  the match up one slot with a write state and a check state, walking the memory.
//  A new request is taken while the previous response waits in out_o.
//  Reset clears the pointers and count; the entry memory needs no clearing.
// ----------------------------------------------------------------------------
module process_fifo_with_key_delete_top #(
  parameter int unsigned QueueDepth = pfkd_pkg::QueueDepthDef
) (
  input logic        clk_i,
  input logic        rst_ni,
  pfkd_in_if.sink    in_i,
  pfkd_out_if.source out_o
);
  import pfkd_pkg::*;

  pfkd_cmd_t  cmd;
  pfkd_stat_t stat;
  entry_t     in_entry;
  entry_t     out_entry;

  // request fields into one entry
  always_comb begin
    in_entry.prio    = in_i.in_priority;
    in_entry.pid     = in_i.in_pid;
    in_entry.runtime = in_i.in_runtime;
  end

  pfkd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  pfkd_dp #(
    .QueueDepth (QueueDepth)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .action_i     (in_i.action),
    .entry_i      (in_entry),
    .out_ready_i  (out_o.ready),
    .out_valid_o  (out_o.valid),
    .out_status_o (out_o.status),
    .out_entry_o  (out_entry),
    .out_occ_o    (out_o.occupancy)
  );

  // response entry onto the channel
  assign out_o.out_priority = out_entry.prio;
  assign out_o.out_pid      = out_entry.pid;
  assign out_o.out_runtime  = out_entry.runtime;

endmodule

@@ design/pfkd_chk.sv @@
// ----------------------------------------------------------------------------
// pfkd_chk
// Port-level checks of the process FIFO, bound to the top level.
// ----------------------------------------------------------------------------
module pfkd_chk #(
  parameter int unsigned QueueDepth = pfkd_pkg::QueueDepthDef
) (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_i,
  input logic                       out_valid_i,
  input logic                       out_ready_i,
  input logic [pfkd_pkg::StatW-1:0] status_i,
  input logic [pfkd_pkg::PrioW-1:0] out_priority_i,
  input logic [pfkd_pkg::PidW-1:0]  out_pid_i,
  input logic [pfkd_pkg::RunW-1:0]  out_runtime_i,
  input logic [pfkd_pkg::OccW-1:0]  occupancy_i
);
  import pfkd_pkg::*;

  localparam logic [OccW-1:0] FullOcc = OccW'(QueueDepth);

  // one request at a time: an accepted word closes the input
  a_one_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("request taken while another is open");

  // a failed action returns no entry
  a_zero_on_fail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (status_i != STAT_OK) |->
      (out_priority_i == '0) && (out_pid_i == '0) && (out_runtime_i == '0))
    else $error("entry fields set on failed action");

  // full is reported only with the queue at capacity
  a_full_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (status_i == STAT_FULL) |-> occupancy_i == FullOcc)
    else $error("full reported below capacity");

  // a stalled response holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(status_i) &&
      $stable(out_pid_i) && $stable(occupancy_i))
    else $error("response changed while stalled");

endmodule

bind process_fifo_with_key_delete_top pfkd_chk #(
  .QueueDepth (QueueDepth)
) u_pfkd_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .status_i       (out_o.status),
  .out_priority_i (out_o.out_priority),
  .out_pid_i      (out_o.out_pid),
  .out_runtime_i  (out_o.out_runtime),
  .occupancy_i    (out_o.occupancy)
);
